// ===== hdl/mse_pkg.sv =====
// Shared types and constants for the merge sort engine.
// No dependencies; imported by mse_mem, mse_seq and merge_sort_engine_unit.
`default_nettype none

package mse_pkg;

    localparam int VALUE_W       = 32;  // element width, fixed by the stream fields
    localparam int MAX_ITEMS_DEF = 64;  // default capacity of one set

    // Sequencer states
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_RUN_SETUP,
        ST_MERGE,
        ST_EMIT_PRIME,
        ST_EMIT
    } mse_state_t;

endpackage : mse_pkg

`default_nettype wire

// ===== hdl/merge_sort_engine_unit.sv =====
// Merge sort engine: load one beat per cycle; on tlast, bottom-up merge over two banks.
// Each run is set up in ST_RUN_SETUP, then merged in ST_MERGE by the single compare/select
// unit writing one element per cycle. Results follow the ST_EMIT_PRIME read, one per cycle
// while m_axis_tready is high; not ready while sorting/emitting.
// Reset (rst_n, async low) clears count, overflow flag and sequencer; buffers keep contents.
// Depends on mse_pkg, mse_mem, mse_seq.
`default_nettype none

module merge_sort_engine_unit
    import mse_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] value
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [31:0] m_axis_tdata,   // [31:0] value_res
    output logic             m_axis_tlast,
    output logic             m_axis_tuser    // [0] overflow
);

    localparam int IDX_W  = $clog2(MAX_ITEMS);
    localparam int ADDR_W = IDX_W + 1;

    logic                we;
    logic [ADDR_W-1:0]   waddr;
    logic [VALUE_W-1:0]  wdata;
    logic [ADDR_W-1:0]   raddr0;
    logic [ADDR_W-1:0]   raddr1;
    logic [VALUE_W-1:0]  rdata0;
    logic [VALUE_W-1:0]  rdata1;

    mse_seq #(
        .MAX_ITEMS (MAX_ITEMS),
        .IDX_W     (IDX_W),
        .ADDR_W    (ADDR_W)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_valid    (s_axis_tvalid),
        .s_ready    (s_axis_tready),
        .s_value    (s_axis_tdata),
        .s_last     (s_axis_tlast),
        .m_valid    (m_axis_tvalid),
        .m_ready    (m_axis_tready),
        .m_last     (m_axis_tlast),
        .m_overflow (m_axis_tuser),
        .mem_we     (we),
        .mem_waddr  (waddr),
        .mem_wdata  (wdata),
        .mem_raddr0 (raddr0),
        .mem_raddr1 (raddr1),
        .mem_rdata0 (rdata0),
        .mem_rdata1 (rdata1)
    );

    mse_mem #(
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk    (clk),
        .we     (we),
        .waddr  (waddr),
        .wdata  (wdata),
        .raddr0 (raddr0),
        .raddr1 (raddr1),
        .rdata0 (rdata0),
        .rdata1 (rdata1)
    );

    // emitted value is the registered read of port 0
    assign m_axis_tdata = rdata0;

endmodule : merge_sort_engine_unit

`default_nettype wire

// ===== hdl/mse_mem.sv =====
// Two-bank element buffer: one write port, two registered read ports.
// Bank select is the address MSB. Depends on mse_pkg.
`default_nettype none

module mse_mem
    import mse_pkg::*;
#(
    parameter int ADDR_W = 7
)
(
    input  wire logic               clk,
    input  wire logic               we,
    input  wire logic [ADDR_W-1:0]  waddr,
    input  wire logic [VALUE_W-1:0] wdata,
    input  wire logic [ADDR_W-1:0]  raddr0,
    input  wire logic [ADDR_W-1:0]  raddr1,
    output logic      [VALUE_W-1:0] rdata0,
    output logic      [VALUE_W-1:0] rdata1
);

    logic [VALUE_W-1:0] mem [2**ADDR_W];
    logic [VALUE_W-1:0] rdata0_reg;
    logic [VALUE_W-1:0] rdata1_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata0_reg <= mem[raddr0];
        rdata1_reg <= mem[raddr1];
    end

    assign rdata0 = rdata0_reg;
    assign rdata1 = rdata1_reg;

endmodule : mse_mem

`default_nettype wire

// ===== hdl/mse_seq.sv =====
// Sequencer for load, bottom-up merge passes and emit, with the shared
// signed compare/select unit. Depends on mse_pkg; drives mse_mem.
`default_nettype none

module mse_seq
    import mse_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF,
    parameter int IDX_W     = $clog2(MAX_ITEMS),
    parameter int ADDR_W    = IDX_W + 1
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // load side
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [VALUE_W-1:0] s_value,
    input  wire logic               s_last,
    // emit side (value comes straight from read port 0)
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_last,
    output logic                    m_overflow,
    // buffer ports
    output logic                    mem_we,
    output logic [ADDR_W-1:0]       mem_waddr,
    output logic [VALUE_W-1:0]      mem_wdata,
    output logic [ADDR_W-1:0]       mem_raddr0,
    output logic [ADDR_W-1:0]       mem_raddr1,
    input  wire logic [VALUE_W-1:0] mem_rdata0,
    input  wire logic [VALUE_W-1:0] mem_rdata1
);

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int EXT_W = CNT_W + 2;

    mse_state_t state_reg, state_next;

    logic [CNT_W-1:0] count_reg,   count_next;
    logic             dropped_reg, dropped_next;
    logic [CNT_W-1:0] width_reg,   width_next;
    logic [CNT_W-1:0] lo_reg,      lo_next;
    logic [CNT_W-1:0] mid_reg,     mid_next;
    logic [CNT_W-1:0] hi_reg,      hi_next;
    logic [CNT_W-1:0] a_reg,       a_next;
    logic [CNT_W-1:0] b_reg,       b_next;
    logic [CNT_W-1:0] k_reg,       k_next;
    logic             src_reg,     src_next;

    logic             s_fire;
    logic             m_fire;
    logic             full;
    logic [CNT_W-1:0] count_inc;
    logic [CNT_W-1:0] k_inc;
    logic             take_a;
    logic [CNT_W-1:0] a_new;
    logic [CNT_W-1:0] b_new;
    logic             run_done;
    logic [EXT_W-1:0] n_x;
    logic [EXT_W-1:0] lo_w_x;
    logic [EXT_W-1:0] lo_2w_x;
    logic [EXT_W-1:0] w2_x;
    logic [CNT_W-1:0] mid_calc;
    logic [CNT_W-1:0] hi_calc;
    logic             pass_done;
    logic             sort_done;
    logic             emit_last;

    // ---------------------------------------------------------------
    // shared datapath: index arithmetic and the compare/select unit
    // ---------------------------------------------------------------
    assign s_fire    = s_valid && s_ready;
    assign m_fire    = m_valid && m_ready;
    assign full      = (count_reg == CNT_W'(MAX_ITEMS));
    assign count_inc = full ? count_reg : count_reg + CNT_W'(1);
    assign k_inc     = k_reg + CNT_W'(1);

    // stable: ties go to the front run
    assign take_a = (a_reg != mid_reg) &&
                    ((b_reg == hi_reg) || ($signed(mem_rdata0) <= $signed(mem_rdata1)));
    assign a_new  = take_a ? a_reg + CNT_W'(1) : a_reg;
    assign b_new  = take_a ? b_reg : b_reg + CNT_W'(1);

    assign run_done  = (k_inc == hi_reg);
    assign n_x       = {2'b00, count_reg};
    assign lo_w_x    = {2'b00, lo_reg} + {2'b00, width_reg};
    assign w2_x      = {1'b0, width_reg, 1'b0};
    assign lo_2w_x   = {2'b00, lo_reg} + w2_x;
    assign mid_calc  = (lo_w_x < n_x)  ? lo_w_x[CNT_W-1:0]  : count_reg;
    assign hi_calc   = (lo_2w_x < n_x) ? lo_2w_x[CNT_W-1:0] : count_reg;
    assign pass_done = (lo_2w_x >= n_x);
    assign sort_done = (w2_x >= n_x);
    assign emit_last = (k_inc == count_reg);

    // ---------------------------------------------------------------
    // next state
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (s_fire && s_last)
                begin
                    state_next = (count_inc > CNT_W'(1)) ? ST_RUN_SETUP : ST_EMIT_PRIME;
                end
            end
            ST_RUN_SETUP:
            begin
                state_next = ST_MERGE;
            end
            ST_MERGE:
            begin
                if (run_done)
                begin
                    state_next = (pass_done && sort_done) ? ST_EMIT_PRIME : ST_RUN_SETUP;
                end
            end
            ST_EMIT_PRIME:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (m_fire && emit_last)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // outputs: handshakes and buffer ports
    // ---------------------------------------------------------------
    always_comb
    begin
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        m_last     = emit_last;
        m_overflow = dropped_reg;
        mem_we     = 1'b0;
        mem_waddr  = {1'b0, count_reg[IDX_W-1:0]};
        mem_wdata  = s_value;
        mem_raddr0 = {src_reg, lo_reg[IDX_W-1:0]};
        mem_raddr1 = {src_reg, mid_calc[IDX_W-1:0]};
        unique case (state_reg)
            ST_LOAD:
            begin
                s_ready = 1'b1;
                mem_we  = s_fire && !full;
            end
            ST_RUN_SETUP:
            begin
                // prime both run heads
            end
            ST_MERGE:
            begin
                mem_we     = 1'b1;
                mem_waddr  = {~src_reg, k_reg[IDX_W-1:0]};
                mem_wdata  = take_a ? mem_rdata0 : mem_rdata1;
                // heads for the next cycle; an exhausted head reads a don't-care entry
                mem_raddr0 = {src_reg, a_new[IDX_W-1:0]};
                mem_raddr1 = {src_reg, b_new[IDX_W-1:0]};
            end
            ST_EMIT_PRIME:
            begin
                mem_raddr0 = {src_reg, {IDX_W{1'b0}}};
            end
            ST_EMIT:
            begin
                m_valid    = 1'b1;
                mem_raddr0 = m_fire ? {src_reg, k_inc[IDX_W-1:0]}
                                    : {src_reg, k_reg[IDX_W-1:0]};
            end
            default:
            begin
                s_ready = 1'b0;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // counters and indexes
    // ---------------------------------------------------------------
    always_comb
    begin
        count_next   = count_reg;
        dropped_next = dropped_reg;
        width_next   = width_reg;
        lo_next      = lo_reg;
        mid_next     = mid_reg;
        hi_next      = hi_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        k_next       = k_reg;
        src_next     = src_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (s_fire)
                begin
                    count_next = count_inc;
                    if (full)
                    begin
                        dropped_next = 1'b1;
                    end
                    if (s_last)
                    begin
                        width_next = CNT_W'(1);
                        lo_next    = '0;
                        src_next   = 1'b0;
                    end
                end
            end
            ST_RUN_SETUP:
            begin
                a_next   = lo_reg;
                b_next   = mid_calc;
                k_next   = lo_reg;
                mid_next = mid_calc;
                hi_next  = hi_calc;
            end
            ST_MERGE:
            begin
                a_next = a_new;
                b_next = b_new;
                k_next = k_inc;
                if (run_done)
                begin
                    if (pass_done)
                    begin
                        lo_next    = '0;
                        width_next = w2_x[CNT_W-1:0];
                        src_next   = ~src_reg;
                    end
                    else
                    begin
                        lo_next = lo_2w_x[CNT_W-1:0];
                    end
                end
            end
            ST_EMIT_PRIME:
            begin
                k_next = '0;
            end
            ST_EMIT:
            begin
                if (m_fire)
                begin
                    k_next = k_inc;
                    if (emit_last)
                    begin
                        count_next   = '0;
                        dropped_next = 1'b0;
                    end
                end
            end
            default:
            begin
                k_next = k_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            width_reg   <= '0;
            lo_reg      <= '0;
            mid_reg     <= '0;
            hi_reg      <= '0;
            a_reg       <= '0;
            b_reg       <= '0;
            k_reg       <= '0;
            src_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            width_reg   <= width_next;
            lo_reg      <= lo_next;
            mid_reg     <= mid_next;
            hi_reg      <= hi_next;
            a_reg       <= a_next;
            b_reg       <= b_next;
            k_reg       <= k_next;
            src_reg     <= src_next;
        end
    end

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ITEMS))
        else $error("item count above capacity");

    a_heads_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MERGE) |-> (a_reg <= mid_reg) && (b_reg <= hi_reg) && (mid_reg <= hi_reg))
        else $error("merge head outside its run");

    a_out_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MERGE) |->
            ({1'b0, k_reg} + {1'b0, mid_reg} == {1'b0, a_reg} + {1'b0, b_reg}))
        else $error("merge output index out of step with heads");

    a_last_starts_sort: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && s_last) |=> (state_reg != ST_LOAD))
        else $error("last beat did not start sort");

    a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && !m_ready) |=> (state_reg == ST_EMIT) && $stable(k_reg))
        else $error("emit index moved while stalled");

endmodule : mse_seq

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for merge_sort_engine_unit: streams sets of signed values,
// sorts a local copy of each set, and compares every output beat with the sorted copy.
// Depends on mse_pkg and the engine RTL.
module tb;
    import mse_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY = MAX_ITEMS_DEF;

    // Value patterns used when building a set
    typedef enum int {
        VAL_ANY,
        VAL_NARROW,
        VAL_EDGES
    } value_mix_t;

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
        logic                      overflow;
    } sorted_beat_t;

    logic               clk;
    logic               rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [31:0]        s_axis_tdata;
    logic               s_axis_tlast;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [31:0]        m_axis_tdata;
    logic               m_axis_tlast;
    logic               m_axis_tuser;

    // Model state: values held for the open set, and beats still owed by the engine
    logic signed [VALUE_W-1:0] open_set[$];
    bit                        open_set_dropped;
    sorted_beat_t              sorted_due[$];

    bit quiet;          // no idling on either side
    int n_mismatch;
    int n_beats;
    int n_sets;
    int n_overflow_sets;
    int n_results;
    int stall_left;

    merge_sort_engine_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("timeout: %0d beats still expected", sorted_due.size());
        $display("end of test: mismatches");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        n_mismatch++;
    endtask

    // Store one accepted beat; on last, sort the set (stable) and queue the results
    function automatic void sort_and_queue(input logic [31:0] data, input logic is_last);
        logic signed [VALUE_W-1:0] ordered[$];
        logic signed [VALUE_W-1:0] key;
        sorted_beat_t              beat;
        int                        j;

        if (open_set.size() < CAPACITY)
            open_set.push_back($signed(data));
        else
            open_set_dropped = 1'b1;
        if (!is_last)
            return;

        ordered = open_set;
        for (int i = 1; i < ordered.size(); i++)
        begin
            key = ordered[i];
            j = i;
            // strict compare keeps equal values in arrival order
            while (j > 0 && ordered[j-1] > key)
            begin
                ordered[j] = ordered[j-1];
                j--;
            end
            ordered[j] = key;
        end
        foreach (ordered[k])
        begin
            beat.value    = ordered[k];
            beat.last     = (k == ordered.size() - 1);
            beat.overflow = open_set_dropped;
            sorted_due.push_back(beat);
        end
        n_sets++;
        if (open_set_dropped)
            n_overflow_sets++;
        open_set.delete();
        open_set_dropped = 1'b0;
    endfunction

    // Output side: compare every accepted beat with the oldest expectation
    always @(posedge clk)
    begin
        sorted_beat_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            n_results++;
            if (sorted_due.size() == 0)
                report_mismatch($sformatf("unexpected beat value=%0d last=%0b ovf=%0b",
                                          $signed(m_axis_tdata), m_axis_tlast, m_axis_tuser));
            else
            begin
                want = sorted_due.pop_front();
                if (m_axis_tdata !== want.value)
                    report_mismatch($sformatf("value got %0d want %0d",
                                              $signed(m_axis_tdata), want.value));
                if (m_axis_tlast !== want.last)
                    report_mismatch($sformatf("tlast got %b want %b (value %0d)",
                                              m_axis_tlast, want.last, want.value));
                if (m_axis_tuser !== want.overflow)
                    report_mismatch($sformatf("overflow got %b want %b (value %0d)",
                                              m_axis_tuser, want.overflow, want.value));
            end
        end
    end

    // Output backpressure: random stall bursts unless quiet
    initial
    begin
        m_axis_tready = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 15) - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Send one beat, optionally after an idle burst; returns once it is taken
    task automatic send_beat(input logic [31:0] data, input logic is_last);
        int gap;
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 15);
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tlast  <= is_last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        n_beats++;
        sort_and_queue(data, is_last);
    endtask

    function automatic logic [31:0] pick_value(input value_mix_t mix);
        case (mix)
            VAL_NARROW: return 32'($signed($urandom_range(0, 6)) - 3);
            VAL_EDGES:
                case ($urandom_range(0, 4))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'hFFFF_FFFF;
                    3: return 32'h0000_0000;
                    default: return $urandom;
                endcase
            default: return $urandom;
        endcase
    endfunction

    task automatic send_set(input int size, input value_mix_t mix);
        for (int i = 0; i < size; i++)
            send_beat(pick_value(mix), i == size - 1);
    endtask

    task automatic send_list(input logic [31:0] vals[$]);
        foreach (vals[i])
            send_beat(vals[i], i == vals.size() - 1);
    endtask

    // drop tvalid first so the last beat is not offered again once the engine is ready
    task automatic wait_drained();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;
        while (sorted_due.size() != 0)
            @(posedge clk);
    endtask

    // Extreme values, single-element set, duplicates, presorted and reversed input
    task automatic test_directed();
        send_list('{32'h8000_0000});
        send_list('{32'h7FFF_FFFF, 32'h8000_0000});
        send_list('{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF,
                    32'h0000_0000});
        send_list('{32'h5555_5555, 32'hAAAA_AAAA, 32'h8000_0001, 32'h7FFF_FFFE,
                    32'h0000_0001});
        send_list('{32'hFFFF_FFFE, 32'h0000_0002, 32'h0000_0010, 32'h7FFF_FFFF});
        send_list('{32'h7FFF_FFFF, 32'h0000_0003, 32'hFFFF_FFFD, 32'h8000_0000});
        wait_drained();
    endtask

    // Mostly small sets, some mid-size, a few near or past capacity
    task automatic test_random_sets();
        int         start;
        int         pick;
        int         size;
        value_mix_t mix;
        start = n_beats;
        while (n_beats - start < 130)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 80)
                size = $urandom_range(1, 12);
            else if (pick < 94)
                size = $urandom_range(13, 40);
            else
                size = $urandom_range(CAPACITY - 1, CAPACITY + 4);
            mix = value_mix_t'($urandom_range(0, 2));
            send_set(size, mix);
        end
        wait_drained();
    endtask

    // No idling: set filled to capacity with its last beat dropped, then small sets
    task automatic test_full_rate();
        quiet = 1'b1;
        send_set(CAPACITY + 1, VAL_NARROW);
        for (int i = 0; i < 6; i++)
            send_set($urandom_range(1, 6), value_mix_t'($urandom_range(0, 2)));
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;
        wait_drained();
    endtask

    initial
    begin
        rst_n            = 1'b0;
        s_axis_tvalid    = 1'b0;
        s_axis_tdata     = '0;
        s_axis_tlast     = 1'b0;
        quiet            = 1'b0;
        open_set_dropped = 1'b0;
        n_mismatch       = 0;
        n_beats          = 0;
        n_sets           = 0;
        n_overflow_sets  = 0;
        n_results        = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random_sets();
        test_full_rate();

        // trailing window catches stray beats after the last set
        repeat (30) @(posedge clk);
        $display("covered %0d input beats in %0d sets (%0d with dropped beats), %0d results",
                 n_beats, n_sets, n_overflow_sets, n_results);
        $display("checked %0d mismatching fields", n_mismatch);
        if (n_mismatch == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
